### hw/rtl/scsa_pkg.sv
// scsa_pkg: shared types and constants of the size-class slot allocator
// fixed field widths, operation and status codes, controller states
// no dependencies
`default_nettype none

package scsa_pkg;

  localparam int OP_W       = 2;
  localparam int SIZE_W     = 32;
  localparam int CLASS_W    = 3;
  localparam int CLS_WIDE_W = 4;   // internal class number, up to 16 classes
  localparam int POOL_W     = 4;
  localparam int SLOT_W     = 22;
  localparam int STATUS_W   = 2;
  localparam int OFFSET_W   = 30;
  localparam int ENTRY_W    = POOL_W + SLOT_W;
  localparam int POOLS_CNT_W = 5;  // pools opened per class, at most 16
  localparam int BUMP_W     = 23;
  localparam int SHIFT_W    = 6;   // base plus class, at most 46
  localparam int BASE_W     = 5;
  localparam int HEADER_W   = 7;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;
  localparam int POOL_FIELD_LIMIT = 16;

  localparam logic [BASE_W-1:0]   BASE_RESET   = 5'd8;
  localparam logic [HEADER_W-1:0] HEADER_RESET = 7'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_UNIT_LOG2 = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES   = 4'd1;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_LOCATE = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK              = 2'd0,
    ST_TOO_LARGE       = 2'd1,
    ST_POOLS_EXHAUSTED = 2'd2,
    ST_STACK_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACCESS,
    S_RESP
  } fsm_t;

  typedef struct packed {
    logic                  found;
    logic [CLS_WIDE_W-1:0] cls;
  } class_sel_t;

endpackage

`default_nettype wire

### hw/rtl/scsa_if.sv
// scsa_if: request, response and configuration channels of the allocator
// valid/ready handshake with payload; depends on scsa_pkg
`default_nettype none

interface scsa_req_if import scsa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [SIZE_W-1:0]    val_bytes;
  logic [CLASS_W-1:0]   req_class;
  logic [POOL_W-1:0]    req_pool;
  logic [SLOT_W-1:0]    req_slot;

  modport source (output valid, operation, val_bytes, req_class, req_pool, req_slot,
                  input ready);
  modport sink   (input valid, operation, val_bytes, req_class, req_pool, req_slot,
                  output ready);
endinterface

interface scsa_rsp_if import scsa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [CLASS_W-1:0]   class_index;
  logic [POOL_W-1:0]    pool_index;
  logic [SLOT_W-1:0]    slot_index;
  logic [OFFSET_W-1:0]  byte_offset;

  modport source (output valid, status, class_index, pool_index, slot_index, byte_offset,
                  input ready);
  modport sink   (input valid, status, class_index, pool_index, slot_index, byte_offset,
                  output ready);
endinterface

interface scsa_cfg_if import scsa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/scsa_ram.sv
// scsa_ram: generic single-clock RAM, one write port, one registered read port
// no dependencies
`default_nettype none

module scsa_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/scsa_class_sel.sv
// scsa_class_sel: picks the smallest size class whose slot holds value plus header
// depends on scsa_pkg
`default_nettype none

module scsa_class_sel import scsa_pkg::*; #(
  parameter int NUM_CLASSES     = 8,
  parameter int POOL_BYTES_LOG2 = 30
) (
  input  logic [SIZE_W-1:0]   val_bytes,
  input  logic [HEADER_W-1:0] header_bytes,
  input  logic [BASE_W-1:0]   base_unit_log2,
  output class_sel_t          sel
);

  localparam logic [SHIFT_W:0] PBL = (SHIFT_W+1)'(POOL_BYTES_LOG2);

  logic [SIZE_W:0] need;

  assign need = {1'b0, val_bytes} + (SIZE_W+1)'(header_bytes);

  // every class compares on its own; the lowest hit wins
  always_comb begin
    logic [SHIFT_W-1:0] sh;
    logic               hit;
    sel = '0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      sh  = SHIFT_W'(base_unit_log2) + SHIFT_W'(c);
      hit = ({1'b0, sh} <= PBL) &&
            ((sh > SHIFT_W'(SIZE_W)) || ({1'b0, need} <= ((SIZE_W+2)'(1) << sh)));
      if (hit) begin
        sel.found = 1'b1;
        sel.cls   = CLS_WIDE_W'(c);
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/size_class_slot_allocator.sv
// size_class_slot_allocator: power-of-two size-class slot allocator
// a request passes the access state, then the result state, where the response is registered
// new requests are taken only in the idle or result state; a stalled response output holds the result state
// per-class depth, pool and bump counters live in registers; free stacks in one RAM
// reset (synchronous, rst high) clears all counters and the response; no RAM clearing pass
`default_nettype none

module size_class_slot_allocator import scsa_pkg::*; #(
  parameter int NUM_CLASSES     = 8,
  parameter int POOL_BYTES_LOG2 = 30,
  parameter int MAX_POOLS       = 16,
  parameter int FREE_DEPTH      = 256
) (
  input  logic       clk,
  input  logic       rst,
  scsa_cfg_if.sink   cfg,
  scsa_req_if.sink   req,
  scsa_rsp_if.source rsp
);

  localparam int CLS_W     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int DEP_IDX_W = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
  localparam int DEP_CNT_W = $clog2(FREE_DEPTH + 1);
  localparam int RAM_AW    = CLS_W + DEP_IDX_W;
  localparam int RAM_DEPTH = 1 << RAM_AW;
  localparam int POOL_LIMIT = (MAX_POOLS < POOL_FIELD_LIMIT) ? MAX_POOLS : POOL_FIELD_LIMIT;

  // configuration
  logic [BASE_W-1:0]   base_unit_log2;
  logic [HEADER_W-1:0] header_bytes;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_unit_log2 <= BASE_RESET;
      header_bytes   <= HEADER_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == CFG_BASE_UNIT_LOG2) begin
        base_unit_log2 <= cfg.data[BASE_W-1:0];
      end else if (cfg.index == CFG_HEADER_BYTES) begin
        header_bytes <= cfg.data[HEADER_W-1:0];
      end
    end
  end

  // control
  fsm_t state, state_next;
  logic accept, out_free, load_out;

  assign out_free = !rsp.valid || rsp.ready;
  assign accept   = req.valid && req.ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept) state_next = S_ACCESS;
      S_ACCESS: state_next = S_RESP;
      S_RESP: begin
        if (out_free) state_next = accept ? S_ACCESS : S_IDLE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    load_out  = 1'b0;
    case (state)
      S_IDLE:   req.ready = 1'b1;
      S_ACCESS: req.ready = 1'b0;
      S_RESP: begin
        req.ready = out_free;
        load_out  = out_free;
      end
      default:  req.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // request capture, class chosen on the way in
  class_sel_t sel;

  scsa_class_sel #(
    .NUM_CLASSES     (NUM_CLASSES),
    .POOL_BYTES_LOG2 (POOL_BYTES_LOG2)
  ) u_class_sel (
    .val_bytes      (req.val_bytes),
    .header_bytes   (header_bytes),
    .base_unit_log2 (base_unit_log2),
    .sel            (sel)
  );

  op_t                   op_q;
  logic                  found_q;
  logic [CLS_WIDE_W-1:0] cls_q;
  logic [POOL_W-1:0]     pool_q;
  logic [SLOT_W-1:0]     slot_q;

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= op_t'(req.operation);
      found_q <= sel.found;
      cls_q   <= (op_t'(req.operation) == OP_ALLOC) ? sel.cls
                                                    : CLS_WIDE_W'(req.req_class);
      pool_q  <= req.req_pool;
      slot_q  <= req.req_slot;
    end
  end

  // per-class counters
  logic [DEP_CNT_W-1:0]   stack_depth [NUM_CLASSES];
  logic [POOLS_CNT_W-1:0] pools_open  [NUM_CLASSES];
  logic [BUMP_W-1:0]      bump_slot   [NUM_CLASSES];

  logic [CLS_W-1:0]       ci;
  logic [DEP_CNT_W-1:0]   dep, dep_m1, dep_next;
  logic [POOLS_CNT_W-1:0] po, po_m1, po_next;
  logic [BUMP_W-1:0]      bu, bu_next;
  logic                   cls_ok, pool_full;
  logic [SHIFT_W:0]       room_log2;
  logic [SHIFT_W-1:0]     spp_log2;

  assign ci     = cls_q[CLS_W-1:0];
  assign dep    = stack_depth[ci];
  assign po     = pools_open[ci];
  assign bu     = bump_slot[ci];
  assign dep_m1 = dep - DEP_CNT_W'(1);
  assign po_m1  = po - POOLS_CNT_W'(1);
  assign cls_ok = {1'b0, cls_q} < (CLS_WIDE_W+1)'(NUM_CLASSES);

  // slots per pool: 2^min(pool log2 - slot log2, 22)
  assign room_log2 = (SHIFT_W+1)'(POOL_BYTES_LOG2)
                   - ((SHIFT_W+1)'(base_unit_log2) + (SHIFT_W+1)'(cls_q));
  assign spp_log2  = (room_log2 >= (SHIFT_W+1)'(SLOT_W)) ? SHIFT_W'(SLOT_W)
                                                         : room_log2[SHIFT_W-1:0];
  assign pool_full = bu >= (BUMP_W'(1) << spp_log2);

  // result of the access stage
  status_t               st_c;
  logic [CLS_WIDE_W-1:0] cls_c;
  logic [POOL_W-1:0]     pool_c;
  logic [SLOT_W-1:0]     slot_c;
  logic                  from_ram_c;
  logic                  ram_we, ram_re;
  logic [RAM_AW-1:0]     ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]    ram_rdata;

  always_comb begin
    st_c       = ST_OK;
    cls_c      = cls_q;
    pool_c     = '0;
    slot_c     = '0;
    from_ram_c = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = {ci, dep[DEP_IDX_W-1:0]};
    ram_raddr  = {ci, dep_m1[DEP_IDX_W-1:0]};
    dep_next   = dep;
    po_next    = po;
    bu_next    = bu;
    case (op_q)
      OP_ALLOC: begin
        if (!found_q) begin
          st_c  = ST_TOO_LARGE;
          cls_c = '0;
        end else if (dep != '0) begin
          // pop the top of the free stack; data arrives next cycle
          ram_re     = 1'b1;
          from_ram_c = 1'b1;
          dep_next   = dep_m1;
        end else if (po == '0 || pool_full) begin
          if (po >= POOLS_CNT_W'(POOL_LIMIT)) begin
            st_c = ST_POOLS_EXHAUSTED;
          end else begin
            po_next = po + POOLS_CNT_W'(1);
            bu_next = BUMP_W'(1);
            pool_c  = po[POOL_W-1:0];
          end
        end else begin
          pool_c  = po_m1[POOL_W-1:0];
          slot_c  = bu[SLOT_W-1:0];
          bu_next = bu + BUMP_W'(1);
        end
      end
      OP_FREE: begin
        if (!cls_ok) begin
          st_c = ST_TOO_LARGE;
        end else begin
          pool_c = pool_q;
          slot_c = slot_q;
          if (dep == DEP_CNT_W'(FREE_DEPTH)) begin
            st_c = ST_STACK_FULL;
          end else begin
            ram_we   = 1'b1;
            dep_next = dep + DEP_CNT_W'(1);
          end
        end
      end
      OP_LOCATE: begin
        if (!cls_ok) begin
          st_c = ST_TOO_LARGE;
        end else begin
          pool_c = pool_q;
          slot_c = slot_q;
        end
      end
      default: begin
        cls_c = '0;
      end
    endcase
    if (state != S_ACCESS) begin
      ram_we = 1'b0;
      ram_re = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        stack_depth[i] <= '0;
        pools_open[i]  <= '0;
        bump_slot[i]   <= '0;
      end
    end else if (state == S_ACCESS) begin
      stack_depth[ci] <= dep_next;
      pools_open[ci]  <= po_next;
      bump_slot[ci]   <= bu_next;
    end
  end

  scsa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RAM_DEPTH)
  ) u_free_stacks (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({pool_q, slot_q}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  status_t               res_st;
  logic [CLS_WIDE_W-1:0] res_cls;
  logic [POOL_W-1:0]     res_pool;
  logic [SLOT_W-1:0]     res_slot;
  logic                  res_from_ram;

  always_ff @(posedge clk) begin
    if (state == S_ACCESS) begin
      res_st       <= st_c;
      res_cls      <= cls_c;
      res_pool     <= pool_c;
      res_slot     <= slot_c;
      res_from_ram <= from_ram_c;
    end
  end

  // result stage: merge popped entry, form the byte offset
  logic [POOL_W-1:0]   fin_pool;
  logic [SLOT_W-1:0]   fin_slot;
  logic [SHIFT_W-1:0]  off_sh;
  logic [OFFSET_W-1:0] fin_off;

  assign fin_pool = res_from_ram ? ram_rdata[ENTRY_W-1:SLOT_W] : res_pool;
  assign fin_slot = res_from_ram ? ram_rdata[SLOT_W-1:0] : res_slot;
  assign off_sh   = SHIFT_W'(base_unit_log2) + SHIFT_W'(res_cls);
  assign fin_off  = OFFSET_W'(fin_slot) << off_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load_out) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp.status      <= res_st;
      rsp.class_index <= res_cls[CLASS_W-1:0];
      rsp.pool_index  <= fin_pool;
      rsp.slot_index  <= fin_slot;
      rsp.byte_offset <= fin_off;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_to_access: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_ACCESS)
    else $error("accepted request did not enter the access stage");

  a_access_to_resp: assert property (@(posedge clk) disable iff (rst)
    state == S_ACCESS |=> state == S_RESP)
    else $error("access stage not followed by result stage");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    ram_re |-> (dep != '0 && !ram_we))
    else $error("free stack pop with empty stack or colliding push");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_ACCESS |-> dep <= DEP_CNT_W'(FREE_DEPTH))
    else $error("free stack depth beyond its bound");
`endif

endmodule

`default_nettype wire
